// File: design/slr_pkg.sv
package slr_pkg;

  localparam int COL_W      = 8;
  localparam int ROW_W      = 9;
  localparam int ADDR_W     = 32;
  localparam int RGB_W      = 24;
  localparam int COLOR_W    = 16;
  localparam int COUNT_W    = 2;
  localparam int STRAIGHT_W = 11;
  localparam int ERR_W      = 12;
  localparam int STEPS_W    = 9;

  localparam int SCREEN_WIDTH = 240;
  localparam int ROW_OFS_W    = ROW_W + $clog2(SCREEN_WIDTH);

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam count_t CNT_NONE  = 2'd0;
  localparam count_t CNT_FIRST = 2'd1;
  localparam count_t CNT_BOTH  = 2'd2;

  // Word address of a pixel; wraps modulo the address width.
  function automatic addr_t pixel_addr(input addr_t base, input col_t x, input row_t y);
    logic [ROW_OFS_W-1:0] row_ofs;
    row_ofs = ROW_OFS_W'(y) * ROW_OFS_W'(SCREEN_WIDTH);
    return base + ADDR_W'(x) + ADDR_W'(row_ofs);
  endfunction

  // RGB888 to RGB565 by dropping the low bits of each channel.
  function automatic color_t to_rgb565(input logic [RGB_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

// File: design/symmetric_line_rasterizer_unit.sv
// Double-ended line rasterizer. A load beat (req_type 0) sets up a line and
// gives no result; each step beat (req_type 1) gives one result beat holding
// up to two pixel addresses, one walked from each end of the line, with last
// set on the final beat of the line. One beat is taken every clock: the line
// state advances by one Bresenham step per beat, and the result lands in an
// output register in the cycle after its step beat is taken. A full output
// register that is not drained holds off new input beats. frame_base should
// be written only while no line is in flight.
module symmetric_line_rasterizer_unit
  import slr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [ADDR_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [COL_W-1:0]    x_start,
  input  logic [ROW_W-1:0]    y_start,
  input  logic [COL_W-1:0]    x_end,
  input  logic [ROW_W-1:0]    y_end,
  input  logic [RGB_W-1:0]    color_rgb,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   first_addr,
  output logic [ADDR_W-1:0]   second_addr,
  output logic [COUNT_W-1:0]  pixel_count,
  output logic [COLOR_W-1:0]  pixel_color,
  output logic                last
);

  addr_t frame_base;

  col_t                    front_x, back_x, front_x_next, back_x_next;
  row_t                    front_y, back_y, front_y_next, back_y_next;
  logic signed [ERR_W-1:0] error_term, error_term_next;
  logic [STRAIGHT_W-1:0]   straight_increment, straight_increment_next;
  logic signed [ERR_W-1:0] diagonal_increment, diagonal_increment_next;
  logic [STEPS_W-1:0]      steps_left, steps_left_next;
  logic                    middle_pending, middle_pending_next;
  logic                    x_major, x_major_next;
  logic                    minor_negative, minor_negative_next;
  color_t                  line_color, line_color_next;
  logic                    busy, busy_next;

  logic   in_fire, step_fire;
  addr_t  res_first, res_second;
  count_t res_count;
  color_t res_color;
  logic   res_last;

  // Load setup.
  col_t                    ld_dx, ld_x1, ld_x2;
  row_t                    ld_dy, ld_y1, ld_y2;
  logic                    ld_x_major, ld_swap;
  logic [ROW_W-1:0]        ld_major, ld_minor;
  logic [STRAIGHT_W-1:0]   ld_straight;
  logic signed [ERR_W-1:0] ld_err, ld_diag;

  // Step datapath.
  logic  diag_step, has_pair, final_pair;
  addr_t front_addr, back_addr;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign step_fire = in_fire && (req_type == REQ_STEP);

  always_comb begin
    ld_dx = (x_start > x_end) ? x_start - x_end : x_end - x_start;
    ld_dy = (y_start > y_end) ? y_start - y_end : y_end - y_start;
    ld_x_major = ROW_W'(ld_dx) > ld_dy;
    ld_swap = ld_x_major ? (x_start > x_end) : (y_start > y_end);
    ld_x1 = ld_swap ? x_end : x_start;
    ld_x2 = ld_swap ? x_start : x_end;
    ld_y1 = ld_swap ? y_end : y_start;
    ld_y2 = ld_swap ? y_start : y_end;
    ld_major = ld_x_major ? ROW_W'(ld_dx) : ld_dy;
    ld_minor = ld_x_major ? ld_dy : ROW_W'(ld_dx);
    ld_straight = STRAIGHT_W'({ld_minor, 1'b0});
    ld_err  = $signed(ERR_W'(ld_straight)) - $signed(ERR_W'(ld_major));
    ld_diag = ld_err - $signed(ERR_W'(ld_major));
  end

  always_comb begin
    diag_step  = error_term > 0;
    has_pair   = steps_left != '0;
    final_pair = (steps_left == STEPS_W'(1)) && !middle_pending;
    front_addr = pixel_addr(frame_base, front_x, front_y);
    back_addr  = pixel_addr(frame_base, back_x, back_y);

    res_first  = '0;
    res_second = '0;
    res_count  = CNT_NONE;
    res_color  = '0;
    res_last   = 1'b1;
    if (busy) begin
      if (has_pair) begin
        res_first  = front_addr;
        res_second = back_addr;
        res_count  = CNT_BOTH;
        res_color  = line_color;
        res_last   = final_pair;
      end else if (middle_pending) begin
        res_first = front_addr;
        res_count = CNT_FIRST;
        res_color = line_color;
      end
    end
  end

  always_comb begin
    front_x_next            = front_x;
    front_y_next            = front_y;
    back_x_next             = back_x;
    back_y_next             = back_y;
    error_term_next         = error_term;
    straight_increment_next = straight_increment;
    diagonal_increment_next = diagonal_increment;
    steps_left_next         = steps_left;
    middle_pending_next     = middle_pending;
    x_major_next            = x_major;
    minor_negative_next     = minor_negative;
    line_color_next         = line_color;
    busy_next               = busy;

    if (in_fire && (req_type == REQ_LOAD)) begin
      front_x_next            = ld_x1;
      front_y_next            = ld_y1;
      back_x_next             = ld_x2;
      back_y_next             = ld_y2;
      straight_increment_next = ld_straight;
      error_term_next         = ld_err;
      diagonal_increment_next = ld_diag;
      steps_left_next         = STEPS_W'((ld_major + ROW_W'(1)) >> 1);
      if (ld_major == '1) begin
        steps_left_next = STEPS_W'(({1'b0, ld_major} + (ROW_W + 1)'(1)) >> 1);
      end
      middle_pending_next     = !ld_major[0];
      x_major_next            = ld_x_major;
      minor_negative_next     = ld_x_major ? !(ld_y2 > ld_y1) : !(ld_x2 > ld_x1);
      line_color_next         = to_rgb565(color_rgb);
      busy_next               = 1'b1;
    end else if (step_fire && busy) begin
      if (has_pair) begin
        // Both ends move one pixel toward the middle along the major axis.
        if (x_major) begin
          front_x_next = front_x + COL_W'(1);
          back_x_next  = back_x - COL_W'(1);
          if (diag_step) begin
            front_y_next = minor_negative ? front_y - ROW_W'(1) : front_y + ROW_W'(1);
            back_y_next  = minor_negative ? back_y + ROW_W'(1) : back_y - ROW_W'(1);
          end
        end else begin
          front_y_next = front_y + ROW_W'(1);
          back_y_next  = back_y - ROW_W'(1);
          if (diag_step) begin
            front_x_next = minor_negative ? front_x - COL_W'(1) : front_x + COL_W'(1);
            back_x_next  = minor_negative ? back_x + COL_W'(1) : back_x - COL_W'(1);
          end
        end
        error_term_next = diag_step ? error_term + diagonal_increment
                                    : error_term + $signed(ERR_W'(straight_increment));
        steps_left_next = steps_left - STEPS_W'(1);
        if (final_pair) begin
          busy_next = 1'b0;
        end
      end else begin
        middle_pending_next = 1'b0;
        busy_next           = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base         <= '0;
      front_x            <= '0;
      front_y            <= '0;
      back_x             <= '0;
      back_y             <= '0;
      error_term         <= '0;
      straight_increment <= '0;
      diagonal_increment <= '0;
      steps_left         <= '0;
      middle_pending     <= 1'b0;
      x_major            <= 1'b0;
      minor_negative     <= 1'b0;
      line_color         <= '0;
      busy               <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_base <= cfg_wr_data;
      end
      front_x            <= front_x_next;
      front_y            <= front_y_next;
      back_x             <= back_x_next;
      back_y             <= back_y_next;
      error_term         <= error_term_next;
      straight_increment <= straight_increment_next;
      diagonal_increment <= diagonal_increment_next;
      steps_left         <= steps_left_next;
      middle_pending     <= middle_pending_next;
      x_major            <= x_major_next;
      minor_negative     <= minor_negative_next;
      line_color         <= line_color_next;
      busy               <= busy_next;
      if (step_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      first_addr  <= res_first;
      second_addr <= res_second;
      pixel_count <= res_count;
      pixel_color <= res_color;
      last        <= res_last;
    end
  end

endmodule
